// File: src/cdr_pkg.sv
// Shared types, constants and helpers for the captive DNS responder.
package cdr_pkg;

  localparam int unsigned HdrBytes  = 12;
  localparam int unsigned AnsTail   = 14;
  localparam logic [7:0]  FlagQr    = 8'h80;
  localparam logic [7:0]  FlagTc    = 8'h02;

  localparam logic [2:0] VerdictOk     = 3'd0;
  localparam logic [2:0] VerdictLong   = 3'd1;
  localparam logic [2:0] VerdictShort  = 3'd2;
  localparam logic [2:0] VerdictNotQry = 3'd3;
  localparam logic [2:0] VerdictTrunc  = 3'd4;
  localparam logic [2:0] VerdictBadQ   = 3'd5;
  localparam logic [2:0] VerdictBig    = 3'd6;

  localparam logic [1:0] RkVerdict = 2'd0;
  localparam logic [1:0] RkByte    = 2'd1;
  localparam logic [1:0] RkNone    = 2'd2;

  typedef struct packed {
    logic       store;
    logic       rd_np;
    logic       copy_init;
    logic       rq_wr;
    logic       qstart_load;
    logic       q_init;
    logic       name_step;
    logic       name_copy_init;
    logic       tail_wr;
    logic       q_next;
    logic       pull_out;
    logic       verdict_out;
    logic [2:0] verdict;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic overflow;
    logic too_short;
    logic not_query;
    logic trunc;
    logic len_big;
    logic qrem_zero;
    logic np_past;
    logic lbl_ptr;
    logic lbl_resv;
    logic lbl_end;
    logic ptr_past;
    logic foot_past;
    logic reply_big;
    logic copy_done;
    logic name_done;
    logic tail_done;
  } sts_t;

  // Answer bytes after the name: type A, class IN, TTL 0, rdlength 4, address.
  function automatic logic [7:0] tail_byte(input logic [3:0] k, input logic [31:0] ip);
    logic [7:0] b;
    unique case (k)
      4'd1, 4'd3: b = 8'd1;
      4'd9:       b = 8'd4;
      4'd10:      b = ip[31:24];
      4'd11:      b = ip[23:16];
      4'd12:      b = ip[15:8];
      4'd13:      b = ip[7:0];
      default:    b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// File: src/cdr_if.sv
// Stream interfaces for request/pull items and result items.
interface cdr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, kind, data_byte, last, input ready);
  modport sink   (input valid, kind, data_byte, last, output ready);
endinterface

interface cdr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  verdict;
  logic [10:0] reply_length;
  logic [7:0]  reply_byte;
  logic        reply_last;
  modport source (output valid, result_kind, verdict, reply_length, reply_byte, reply_last,
                  input ready);
  modport sink   (input valid, result_kind, verdict, reply_length, reply_byte, reply_last,
                  output ready);
endinterface

// File: src/cdr_ctrl.sv
// Controller: sequences loading, validation walk, reply build and readout.
module cdr_ctrl import cdr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_kind_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StPull   = 4'd1;
  localparam logic [3:0] StJudge  = 4'd2;
  localparam logic [3:0] StCrd    = 4'd3;
  localparam logic [3:0] StCwr    = 4'd4;
  localparam logic [3:0] StQload  = 4'd5;
  localparam logic [3:0] StQstart = 4'd6;
  localparam logic [3:0] StNrd    = 4'd7;
  localparam logic [3:0] StNex    = 4'd8;
  localparam logic [3:0] StFoot   = 4'd9;
  localparam logic [3:0] StNcrd   = 4'd10;
  localparam logic [3:0] StNcwr   = 4'd11;
  localparam logic [3:0] StTail   = 4'd12;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle) && !sts_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_kind_i) begin
            state_d = StPull;
          end else begin
            cmd_o.store = 1'b1;
            if (in_last_i) state_d = StJudge;
          end
        end
      end
      StPull: begin
        cmd_o.pull_out = 1'b1;
        state_d        = StIdle;
      end
      StJudge: begin
        cmd_o.verdict_out = 1'b1;
        state_d           = StIdle;
        priority if (sts_i.overflow)  cmd_o.verdict = VerdictLong;
        else if (sts_i.too_short)     cmd_o.verdict = VerdictShort;
        else if (sts_i.not_query)     cmd_o.verdict = VerdictNotQry;
        else if (sts_i.trunc)         cmd_o.verdict = VerdictTrunc;
        else if (sts_i.len_big)       cmd_o.verdict = VerdictBig;
        else begin
          cmd_o.verdict_out = 1'b0;
          cmd_o.copy_init   = 1'b1;
          state_d           = StCrd;
        end
      end
      StCrd: state_d = sts_i.copy_done ? StQload : StCwr;
      StCwr: begin
        cmd_o.rq_wr = 1'b1;
        state_d     = StCrd;
      end
      StQload: begin
        cmd_o.qstart_load = 1'b1;
        state_d           = StQstart;
      end
      StQstart: begin
        if (sts_i.qrem_zero) begin
          cmd_o.verdict_out = 1'b1;
          cmd_o.verdict     = VerdictOk;
          state_d           = StIdle;
        end else begin
          cmd_o.q_init = 1'b1;
          state_d      = StNrd;
        end
      end
      StNrd: begin
        cmd_o.rd_np = 1'b1;
        if (sts_i.np_past) begin
          cmd_o.verdict_out = 1'b1;
          cmd_o.verdict     = VerdictBadQ;
          state_d           = StIdle;
        end else begin
          state_d = StNex;
        end
      end
      StNex: begin
        priority if (sts_i.lbl_ptr && sts_i.ptr_past) begin
          cmd_o.verdict_out = 1'b1;
          cmd_o.verdict     = VerdictBadQ;
          state_d           = StIdle;
        end else if (sts_i.lbl_ptr || sts_i.lbl_end) begin
          cmd_o.name_step = 1'b1;
          state_d         = StFoot;
        end else if (sts_i.lbl_resv) begin
          cmd_o.verdict_out = 1'b1;
          cmd_o.verdict     = VerdictBadQ;
          state_d           = StIdle;
        end else begin
          cmd_o.name_step = 1'b1;
          state_d         = StNrd;
        end
      end
      StFoot: begin
        priority if (sts_i.foot_past) begin
          cmd_o.verdict_out = 1'b1;
          cmd_o.verdict     = VerdictBadQ;
          state_d           = StIdle;
        end else if (sts_i.reply_big) begin
          cmd_o.verdict_out = 1'b1;
          cmd_o.verdict     = VerdictBig;
          state_d           = StIdle;
        end else begin
          cmd_o.name_copy_init = 1'b1;
          state_d              = StNcrd;
        end
      end
      StNcrd: state_d = sts_i.name_done ? StTail : StNcwr;
      StNcwr: begin
        cmd_o.rq_wr = 1'b1;
        state_d     = StNcrd;
      end
      StTail: begin
        cmd_o.tail_wr = 1'b1;
        if (sts_i.tail_done) begin
          cmd_o.q_next = 1'b1;
          state_d      = StQstart;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/cdr_dp.sv
// Datapath: request and reply stores, walk pointers, checks and result register.
module cdr_dp import cdr_pkg::*; #(
  parameter int unsigned REQUEST_BYTES = 512,
  parameter int unsigned REPLY_BYTES   = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] ip_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [2:0]  verdict_o,
  output logic [10:0] reply_length_o,
  output logic [7:0]  reply_byte_o,
  output logic        reply_last_o
);

  localparam int unsigned CW  = $clog2(REQUEST_BYTES + 1);
  localparam int unsigned RAW = $clog2(REQUEST_BYTES);
  localparam int unsigned QW  = $clog2(REQUEST_BYTES + 80) + 1;
  localparam int unsigned PAW = $clog2(REPLY_BYTES);
  localparam int unsigned RTW = $clog2(REPLY_BYTES + 1);
  localparam int unsigned WW  = $clog2(REPLY_BYTES + REQUEST_BYTES + 96) + 1;

  logic [7:0] req_mem [REQUEST_BYTES];
  logic [7:0] rep_mem [REPLY_BYTES];
  logic [7:0] hdr_q [HdrBytes];

  logic [7:0]     req_rdata_q, rep_rdata_q;
  logic [CW-1:0]  count_q;
  logic           overflow_q;
  logic [QW-1:0]  cp_q, np_q, qs_q;
  logic [WW-1:0]  wr_q;
  logic [3:0]     phase_q;
  logic [15:0]    qrem_q;
  logic [RTW-1:0] total_q, pos_q;

  logic [QW-1:0]  len_q, rd_ptr;
  logic [WW-1:0]  need;
  logic [7:0]     copy_byte, wr_byte;
  logic           rep_we, have_byte;

  assign len_q  = QW'(count_q);
  assign rd_ptr = cmd_i.rd_np ? np_q : cp_q;

  // Header fields patched while copying: QR set, answer count = question count.
  always_comb begin
    copy_byte = req_rdata_q;
    if (wr_q == WW'(2))      copy_byte = req_rdata_q | FlagQr;
    else if (wr_q == WW'(6)) copy_byte = hdr_q[4];
    else if (wr_q == WW'(7)) copy_byte = hdr_q[5];
  end

  assign wr_byte = cmd_i.rq_wr ? copy_byte : tail_byte(phase_q, ip_i);
  assign rep_we  = cmd_i.rq_wr || cmd_i.tail_wr;
  assign need    = wr_q + WW'(np_q - qs_q) + WW'(AnsTail);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && (count_q < CW'(REQUEST_BYTES))) begin
      req_mem[count_q[RAW-1:0]] <= data_byte_i;
    end
    req_rdata_q <= req_mem[rd_ptr[RAW-1:0]];
    if (rep_we) begin
      rep_mem[wr_q[PAW-1:0]] <= wr_byte;
    end
    rep_rdata_q <= rep_mem[pos_q[PAW-1:0]];
    if (cmd_i.store && (count_q < CW'(HdrBytes))) begin
      hdr_q[count_q[3:0]] <= data_byte_i;
    end
  end

  assign have_byte = pos_q < total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      overflow_q     <= 1'b0;
      cp_q           <= '0;
      np_q           <= '0;
      qs_q           <= '0;
      wr_q           <= '0;
      phase_q        <= '0;
      qrem_q         <= '0;
      total_q        <= '0;
      pos_q          <= '0;
      out_valid_o    <= 1'b0;
      result_kind_o  <= RkVerdict;
      verdict_o      <= VerdictOk;
      reply_length_o <= '0;
      reply_byte_o   <= '0;
      reply_last_o   <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.store) begin
        if (count_q < CW'(REQUEST_BYTES)) count_q <= count_q + CW'(1);
        else overflow_q <= 1'b1;
      end
      if (cmd_i.copy_init) begin
        cp_q <= '0;
        wr_q <= '0;
      end
      if (cmd_i.rq_wr) begin
        cp_q <= cp_q + QW'(1);
        wr_q <= wr_q + WW'(1);
      end
      if (cmd_i.qstart_load) begin
        qs_q   <= QW'(HdrBytes);
        qrem_q <= {hdr_q[4], hdr_q[5]};
      end
      if (cmd_i.q_init) np_q <= qs_q;
      if (cmd_i.name_step) begin
        priority if (req_rdata_q[7:6] == 2'b11) np_q <= np_q + QW'(2);
        else np_q <= np_q + QW'(1) + QW'(req_rdata_q);
      end
      if (cmd_i.name_copy_init) begin
        cp_q    <= qs_q;
        phase_q <= '0;
      end
      if (cmd_i.tail_wr) begin
        wr_q    <= wr_q + WW'(1);
        phase_q <= phase_q + 4'd1;
      end
      if (cmd_i.q_next) begin
        qs_q   <= np_q + QW'(4);
        qrem_q <= qrem_q - 16'd1;
      end
      if (cmd_i.pull_out) begin
        out_valid_o    <= 1'b1;
        verdict_o      <= VerdictOk;
        reply_length_o <= '0;
        if (have_byte) begin
          result_kind_o <= RkByte;
          reply_byte_o  <= rep_rdata_q;
          reply_last_o  <= (pos_q + RTW'(1)) == total_q;
          pos_q         <= pos_q + RTW'(1);
        end else begin
          result_kind_o <= RkNone;
          reply_byte_o  <= '0;
          reply_last_o  <= 1'b0;
        end
      end
      if (cmd_i.verdict_out) begin
        out_valid_o    <= 1'b1;
        result_kind_o  <= RkVerdict;
        verdict_o      <= cmd_i.verdict;
        reply_byte_o   <= '0;
        reply_last_o   <= 1'b0;
        reply_length_o <= (cmd_i.verdict == VerdictOk) ? 11'(wr_q) : 11'd0;
        total_q        <= (cmd_i.verdict == VerdictOk) ? RTW'(wr_q) : '0;
        pos_q          <= '0;
        count_q        <= '0;
        overflow_q     <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.out_busy  = out_valid_o;
    sts_o.overflow  = overflow_q;
    sts_o.too_short = count_q < CW'(HdrBytes);
    sts_o.not_query = (|{hdr_q[6], hdr_q[7], hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]})
                      || ((hdr_q[2] & FlagQr) != 8'd0);
    sts_o.trunc     = (hdr_q[2] & FlagTc) != 8'd0;
    sts_o.len_big   = WW'(count_q) > WW'(REPLY_BYTES);
    sts_o.qrem_zero = qrem_q == 16'd0;
    sts_o.np_past   = np_q >= len_q;
    sts_o.lbl_ptr   = req_rdata_q[7:6] == 2'b11;
    sts_o.lbl_resv  = ^req_rdata_q[7:6];
    sts_o.lbl_end   = req_rdata_q == 8'd0;
    sts_o.ptr_past  = (np_q + QW'(1)) >= len_q;
    sts_o.foot_past = (np_q + QW'(4)) > len_q;
    sts_o.reply_big = need > WW'(REPLY_BYTES);
    sts_o.copy_done = cp_q == len_q;
    sts_o.name_done = cp_q == np_q;
    sts_o.tail_done = phase_q == 4'(AnsTail - 1);
  end

endmodule

// File: src/captive_dns_responder.sv
// Captive DNS responder top level: APB register, controller and datapath.
// Load items (kind 0) are taken one per cycle while the result register is
// empty; a pull (kind 1) moves the registered reply store read into it in a
// pull state. On the last request byte the controller walks the request out
// of the request store's single read port: a judge state for header checks,
// a read and a write state per request byte for the copy, and per question a
// start state, a read and an examine state per label (the terminating byte or
// pointer counts as one), a footer and size check state, a read and a write
// state per name byte and a tail state for the 14-byte fixed answer tail. The
// verdict is then held in the result register; no item is taken meanwhile.
module captive_dns_responder import cdr_pkg::*; #(
  parameter int unsigned REQUEST_BYTES = 512,
  parameter int unsigned REPLY_BYTES   = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  cdr_in_if.sink      in_i,
  cdr_out_if.source   out_o
);

  logic [31:0] ip_q;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : ip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      ip_q <= pwdata;
    end
  end

  cdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cdr_dp #(
    .REQUEST_BYTES (REQUEST_BYTES),
    .REPLY_BYTES   (REPLY_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .data_byte_i    (in_i.data_byte),
    .ip_i           (ip_q),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_kind_o  (out_o.result_kind),
    .verdict_o      (out_o.verdict),
    .reply_length_o (out_o.reply_length),
    .reply_byte_o   (out_o.reply_byte),
    .reply_last_o   (out_o.reply_last)
  );

endmodule
